// ===== sv/tlaq_pkg.sv =====
// Package for the text line assembler queue: transaction payload types,
// mode and result codes, character constants and flag bits.
// No dependencies.
package tlaq_pkg;

  // Input modes
  localparam logic [1:0] MODE_BYTE      = 2'd0;
  localparam logic [1:0] MODE_UART_ERR  = 2'd1;
  localparam logic [1:0] MODE_TAKE_LINE = 2'd2;
  localparam logic [1:0] MODE_TAKE_ERR  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_NO_LINE = 2'd2;
  localparam logic [1:0] KIND_ERR_REP = 2'd3;

  // Characters
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Receive flag bits
  localparam logic [3:0] FLAG_TOO_LONG   = 4'b0001;
  localparam logic [3:0] FLAG_QUEUE_FULL = 4'b0010;
  localparam logic [3:0] FLAG_INVALID    = 4'b0100;
  localparam logic [3:0] FLAG_UART_ERR   = 4'b1000;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [3:0] uart_error_bits;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] line_char;
    logic       last;
    logic [3:0] rx_flags;
    logic [3:0] uart_err_accum;
    logic [2:0] queued_lines;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_e;

endpackage

// ===== sv/tlaq_line_mem.sv =====
// Line character memory: one write port, one read port, registered read data.
// Holds the line being assembled and the queued lines, one slot per line.
// No dependencies.
module tlaq_line_mem #(
  parameter int DW    = 8,
  parameter int AW    = 9,
  parameter int DEPTH = 320
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/text_line_assembler_queue_core.sv =====
// Text line assembler queue, top level.
// Depends on tlaq_pkg and tlaq_line_mem.
//
// Usage: input transactions (in_valid_i / in_stall_o, payload in_data_i) carry
// a received byte, a uart error event, a take-line request or a take-errors
// request. Results leave on out_valid_o / out_stall_i with payload out_data_o.
// Bytes are written straight into a free slot of the line memory, so ending a
// line only moves the write slot pointer; the memory has QUEUE_DEPTH+1 slots.
// A byte, uart error or take-errors transaction gives one result, registered
// at the accepting edge and offered in the next cycle; the next transaction is
// taken at the next edge if the output register is free or being drained.
// A take-line transaction with a line waiting streams its characters from the
// memory read port, through the read data register into the output register,
// one character per cycle while the output is not stalled; new input is held
// off until the last character is registered.
// A stall on the output holds the output register and the prefetched
// character, and pauses the stream without losing data.
// Reset clears the pointers, counts, flags and the output valid; memory
// contents need no clearing since only written entries are read.
module text_line_assembler_queue_core
  import tlaq_pkg::*;
#(
  parameter int LINE_LEN    = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int NS    = QUEUE_DEPTH + 1;
  localparam int IW    = $clog2(LINE_LEN);
  localparam int SW    = $clog2(NS);
  localparam int AW    = SW + IW;
  localparam int DEPTH = NS * (2 ** IW);
  localparam logic [IW-1:0] MAX_LEN   = IW'(LINE_LEN - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NS - 1);
  localparam logic [SW-1:0] FULL_CNT  = SW'(QUEUE_DEPTH);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  state_e        state_q, state_d;
  logic [IW-1:0] plen_q, plen_d;
  logic          disc_q, disc_d;
  logic [3:0]    flags_q, flags_d;
  logic [3:0]    uerr_q, uerr_d;
  logic [SW-1:0] wslot_q, wslot_d;
  logic [SW-1:0] rslot_q, rslot_d;
  logic [SW-1:0] count_q, count_d;
  logic [IW-1:0] slot_len_q [NS];

  // Stream state
  logic [SW-1:0] st_slot_q, st_slot_d;
  logic [IW-1:0] st_len_q, st_len_d;
  logic [IW-1:0] iss_idx_q, iss_idx_d;
  logic          rv_q, rv_d;
  logic          rlast_q, rlast_d;

  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          in_acc, out_free, re, consume, commit;
  logic          we;
  logic [7:0]    rdata;
  logic [7:0]    b;
  logic          is_eol, is_erase, is_print;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign b        = in_data_i.data_byte;
  assign is_eol   = (b == CH_LF) || (b == CH_CR);
  assign is_erase = (b == CH_BS) || (b == CH_DEL);
  assign is_print = ((b >= CH_SPACE) && (b <= CH_TILDE)) || (b == CH_TAB);

  // Stream read issue and consumption of the prefetched character
  assign consume = (state_q == ST_STREAM) && rv_q && out_free;
  assign re      = (state_q == ST_STREAM) && (iss_idx_q != st_len_q) && (!rv_q || out_free);

  // Main transaction logic
  always_comb begin
    state_d     = state_q;
    plen_d      = plen_q;
    disc_d      = disc_q;
    flags_d     = flags_q;
    uerr_d      = uerr_q;
    wslot_d     = wslot_q;
    rslot_d     = rslot_q;
    count_d     = count_q;
    st_slot_d   = st_slot_q;
    st_len_d    = st_len_q;
    iss_idx_d   = iss_idx_q;
    rv_d        = rv_q;
    rlast_d     = rlast_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    commit      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_d.kind           = KIND_ACK;
          out_d.line_char      = '0;
          out_d.last           = 1'b1;
          out_d.uart_err_accum = '0;
          out_valid_d          = 1'b1;
          case (in_data_i.mode)
            MODE_BYTE: begin
              if (is_eol) begin
                if (disc_q) begin
                  disc_d = 1'b0;
                  plen_d = '0;
                end else if (plen_q != '0) begin
                  if (count_q != FULL_CNT) begin
                    commit  = 1'b1;
                    wslot_d = slot_inc(wslot_q);
                    count_d = count_q + 1'b1;
                  end else begin
                    flags_d = flags_q | FLAG_QUEUE_FULL;
                  end
                  plen_d = '0;
                end
              end else if (disc_q) begin
                // dropped until end of line
              end else if (is_erase) begin
                if (plen_q != '0) begin
                  plen_d = plen_q - 1'b1;
                end
              end else if (is_print) begin
                if (plen_q < MAX_LEN) begin
                  we     = 1'b1;
                  plen_d = plen_q + 1'b1;
                end else begin
                  plen_d  = '0;
                  disc_d  = 1'b1;
                  flags_d = flags_q | FLAG_TOO_LONG;
                end
              end else begin
                plen_d  = '0;
                disc_d  = 1'b1;
                flags_d = flags_q | FLAG_INVALID;
              end
              out_d.rx_flags = flags_d;
            end
            MODE_UART_ERR: begin
              uerr_d         = uerr_q | in_data_i.uart_error_bits;
              flags_d        = flags_q | FLAG_UART_ERR;
              plen_d         = '0;
              disc_d         = 1'b0;
              out_d.rx_flags = flags_d;
            end
            MODE_TAKE_LINE: begin
              out_d.rx_flags = flags_q;
              if (count_q == '0) begin
                out_d.kind = KIND_NO_LINE;
              end else begin
                out_valid_d = 1'b0;
                state_d     = ST_STREAM;
                st_slot_d   = rslot_q;
                st_len_d    = slot_len_q[rslot_q];
                iss_idx_d   = '0;
                rv_d        = 1'b0;
                rslot_d     = slot_inc(rslot_q);
                count_d     = count_q - 1'b1;
              end
            end
            default: begin
              out_d.kind           = KIND_ERR_REP;
              out_d.rx_flags       = flags_q;
              out_d.uart_err_accum = uerr_q;
              flags_d              = '0;
              uerr_d               = '0;
            end
          endcase
          out_d.queued_lines = 3'(count_d);
        end
      end
      ST_STREAM: begin
        if (consume) begin
          out_valid_d          = 1'b1;
          out_d.kind           = KIND_CHAR;
          out_d.line_char      = rdata;
          out_d.last           = rlast_q;
          out_d.rx_flags       = flags_q;
          out_d.uart_err_accum = '0;
          out_d.queued_lines   = 3'(count_q);
          rv_d                 = 1'b0;
          if (rlast_q) begin
            state_d = ST_IDLE;
          end
        end
        if (re) begin
          rv_d      = 1'b1;
          rlast_d   = (iss_idx_q == st_len_q - 1'b1);
          iss_idx_d = iss_idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      plen_q      <= '0;
      disc_q      <= 1'b0;
      flags_q     <= '0;
      uerr_q      <= '0;
      wslot_q     <= '0;
      rslot_q     <= '0;
      count_q     <= '0;
      iss_idx_q   <= '0;
      rv_q        <= 1'b0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plen_q      <= plen_d;
      disc_q      <= disc_d;
      flags_q     <= flags_d;
      uerr_q      <= uerr_d;
      wslot_q     <= wslot_d;
      rslot_q     <= rslot_d;
      count_q     <= count_d;
      iss_idx_q   <= iss_idx_d;
      rv_q        <= rv_d;
      rlast_q     <= rlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    st_slot_q <= st_slot_d;
    st_len_q  <= st_len_d;
    out_q     <= out_d;
  end

  // Slot lengths, written when a line is queued
  always_ff @(posedge clk_i) begin
    if (commit) begin
      slot_len_q[wslot_q] <= plen_q;
    end
  end

  tlaq_line_mem #(
    .DW    (8),
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({wslot_q, plen_q}),
    .wdata_i (b),
    .re_i    (re),
    .raddr_i ({st_slot_q, iss_idx_q}),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== verif/tlaq_line_scoreboard_pkg.sv =====
// Scoreboard for the text line assembler queue: a line/queue predictor and
// an in-order result checker with its own error count.
// Depends on tlaq_pkg for the payload types, codes and character constants.
package tlaq_line_scoreboard_pkg;
  import tlaq_pkg::*;

  localparam int LINE_LEN    = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_PRINTS  = 40;

  class line_queue_scoreboard;
    // predicted block state
    logic [7:0]  partial_line [LINE_LEN];
    int unsigned partial_len;
    bit          discarding;
    logic [7:0]  slot_chars [QUEUE_DEPTH][LINE_LEN];
    int unsigned slot_len [QUEUE_DEPTH];
    int unsigned rd_slot;
    int unsigned wr_slot;
    int unsigned lines_waiting;
    logic [3:0]  flags;
    logic [3:0]  uart_acc;

    // results still owed by the block, oldest first
    out_t        owed_results [$];
    int unsigned error_count;
    int unsigned result_index;

    function new();
      partial_len   = 0;
      discarding    = 1'b0;
      rd_slot       = 0;
      wr_slot       = 0;
      lines_waiting = 0;
      flags         = '0;
      uart_acc      = '0;
      error_count   = 0;
      result_index  = 0;
    endfunction

    function void owe_result(logic [1:0] kind, logic [7:0] ch, logic fin,
                             logic [3:0] f, logic [3:0] ue);
      out_t r;
      r.kind           = kind;
      r.line_char      = ch;
      r.last           = fin;
      r.rx_flags       = f;
      r.uart_err_accum = ue;
      r.queued_lines   = 3'(lines_waiting);
      owed_results.push_back(r);
    endfunction

    function void begin_discard(logic [3:0] flag);
      partial_len = 0;
      discarding  = 1'b1;
      flags       = flags | flag;
    endfunction

    // Applies one received byte; returns 0 when the byte leaves the state alone.
    function bit apply_byte(logic [7:0] b);
      int unsigned i;
      if (b == CH_LF || b == CH_CR) begin
        if (discarding) begin
          discarding  = 1'b0;
          partial_len = 0;
          return 1'b1;
        end
        if (partial_len == 0) return 1'b0;
        if (lines_waiting < QUEUE_DEPTH) begin
          for (i = 0; i < partial_len; i++) slot_chars[wr_slot][i] = partial_line[i];
          slot_len[wr_slot] = partial_len;
          wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
          lines_waiting++;
        end else begin
          flags = flags | FLAG_QUEUE_FULL;
        end
        partial_len = 0;
        return 1'b1;
      end
      if (discarding) return 1'b0;
      if (b == CH_BS || b == CH_DEL) begin
        if (partial_len == 0) return 1'b0;
        partial_len--;
        return 1'b1;
      end
      if ((b >= CH_SPACE && b <= CH_TILDE) || b == CH_TAB) begin
        if (partial_len < LINE_LEN - 1) begin
          partial_line[partial_len] = b;
          partial_len++;
        end else begin
          begin_discard(FLAG_TOO_LONG);
        end
        return 1'b1;
      end
      begin_discard(FLAG_INVALID);
      return 1'b1;
    endfunction

    // Notes an accepted input transaction and queues what it must produce.
    // Returns 0 for a transaction that the block simply ignores.
    function bit note_input(in_t item);
      bit          effective;
      int unsigned i;
      int unsigned r;
      effective = 1'b1;
      case (item.mode)
        MODE_BYTE: begin
          effective = apply_byte(item.data_byte);
          owe_result(KIND_ACK, '0, 1'b1, flags, '0);
        end
        MODE_UART_ERR: begin
          uart_acc    = uart_acc | item.uart_error_bits;
          flags       = flags | FLAG_UART_ERR;
          partial_len = 0;
          discarding  = 1'b0;
          owe_result(KIND_ACK, '0, 1'b1, flags, '0);
        end
        MODE_TAKE_LINE: begin
          if (lines_waiting == 0) begin
            owe_result(KIND_NO_LINE, '0, 1'b1, flags, '0);
          end else begin
            r       = rd_slot;
            rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
            lines_waiting--;
            for (i = 0; i < slot_len[r]; i++)
              owe_result(KIND_CHAR, slot_chars[r][i], i + 1 == slot_len[r], flags, '0);
          end
        end
        MODE_TAKE_ERR: begin
          owe_result(KIND_ERR_REP, '0, 1'b1, flags, uart_acc);
          flags    = '0;
          uart_acc = '0;
        end
      endcase
      return effective;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    task report_error(string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("SB ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_error($sformatf("result %0d %s: got %0h want %0h",
                               result_index, name, got, want));
    endtask

    // Checks one accepted output transaction against the oldest owed result.
    task check_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        report_error($sformatf("result %0d not owed: %h", result_index, got));
        result_index++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", 8'(got.kind), 8'(want.kind));
      compare_field("line_char", got.line_char, want.line_char);
      compare_field("last", 8'(got.last), 8'(want.last));
      compare_field("rx_flags", 8'(got.rx_flags), 8'(want.rx_flags));
      compare_field("uart_err_accum", 8'(got.uart_err_accum), 8'(want.uart_err_accum));
      compare_field("queued_lines", 8'(got.queued_lines), 8'(want.queued_lines));
      result_index++;
    endtask
  endclass

endpackage

// ===== verif/tb_text_line_assembler_queue_core.sv =====
// Testbench top for text_line_assembler_queue_core: drives byte, error and
// take transactions with random idling and one long output hold-off.
// Depends on tlaq_pkg and tlaq_line_scoreboard_pkg.
module tb_text_line_assembler_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tlaq_pkg::*;
  import tlaq_line_scoreboard_pkg::*;

  localparam int ITEM_TARGET    = 460;
  localparam int IDLE_PCT       = 15;
  localparam int STALL_HOLD     = 300;
  localparam int PRESSURE_AT    = 30;
  localparam int QUIET_FIRST    = 250;
  localparam int QUIET_LAST     = 340;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  line_queue_scoreboard sb;
  int unsigned items_taken     = 0;
  int unsigned idle_cycles     = 0;
  int unsigned rx_hold_left    = 0;
  bit          rx_hold_done    = 1'b0;

  text_line_assembler_queue_core #(
    .LINE_LEN    (LINE_LEN),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // stretch of the run where neither side idles
  function bit quiet_window();
    return items_taken >= QUIET_FIRST && items_taken < QUIET_LAST;
  endfunction

  function logic [7:0] rand_printable();
    if ($urandom_range(15) == 0) return CH_TAB;
    return 8'($urandom_range(CH_SPACE, CH_TILDE));
  endfunction

  function logic [7:0] rand_eol();
    return $urandom_range(1) ? CH_CR : CH_LF;
  endfunction

  // a byte that is neither text, end of line nor erase
  function logic [7:0] rand_invalid();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while ((b >= CH_SPACE && b <= CH_TILDE) || b == CH_TAB || b == CH_CR ||
           b == CH_LF || b == CH_BS || b == CH_DEL)
      b = 8'($urandom_range(255));
    return b;
  endfunction

  // Offers one transaction, idling first at random; valid stays high on return.
  task send_item(in_t item);
    while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_taken++;
    void'(sb.note_input(item));
  endtask

  task send_byte(logic [7:0] b);
    in_t t;
    t.mode            = MODE_BYTE;
    t.data_byte       = b;
    t.uart_error_bits = 4'($urandom_range(15));
    send_item(t);
  endtask

  task send_cmd(logic [1:0] mode, logic [3:0] ue);
    in_t t;
    t.mode            = mode;
    t.data_byte       = 8'($urandom_range(255));
    t.uart_error_bits = ue;
    send_item(t);
  endtask

  // Text line of len characters, optionally with erase bytes mixed in
  task send_line(int unsigned len, bit edits);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (edits && $urandom_range(9) == 0) send_byte($urandom_range(1) ? CH_BS : CH_DEL);
      send_byte(rand_printable());
    end
    send_byte(rand_eol());
  endtask

  // One randomly chosen chunk of traffic
  task random_chunk();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 45) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 12);
      send_line(len, 1'b1);
    end else if (pick < 70) begin
      send_cmd(MODE_TAKE_LINE, 4'($urandom_range(15)));
    end else if (pick < 76) begin
      send_cmd(MODE_TAKE_ERR, 4'($urandom_range(15)));
    end else if (pick < 81) begin
      send_cmd(MODE_UART_ERR, 4'($urandom_range(15)));
    end else if (pick < 89) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 95) begin
      // broken line: text, a bad byte, more text, end of line
      repeat ($urandom_range(0, 4)) send_byte(rand_printable());
      send_byte(rand_invalid());
      repeat ($urandom_range(0, 4)) send_byte(rand_printable());
      send_byte(rand_eol());
    end else begin
      send_byte($urandom_range(1) ? rand_eol() : CH_DEL);
    end
  endtask

  // Reset, stimulus and final verdict
  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, clean flags, erase and end of line on empty
    send_cmd(MODE_TAKE_LINE, 4'h0);
    send_cmd(MODE_TAKE_ERR, 4'h0);
    send_byte(CH_BS);
    send_byte(CH_CR);
    // text extremes, erase both ways, queue and read a line
    send_byte(CH_SPACE);
    send_byte(CH_TAB);
    send_byte(CH_TILDE);
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte(rand_printable());
    send_byte(CH_LF);
    send_cmd(MODE_TAKE_LINE, 4'hF);
    // invalid bytes, input dropped and erase ignored while discarding
    send_byte(8'h00);
    send_byte(rand_printable());
    send_byte(CH_BS);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(8'h80);
    send_byte(CH_CR);
    // uart error drops the partial line
    send_cmd(MODE_UART_ERR, 4'hF);
    send_byte(rand_printable());
    send_cmd(MODE_UART_ERR, 4'h0);
    send_byte(CH_CR);
    send_cmd(MODE_TAKE_ERR, 4'h0);

    // longest line, then one character too many, then a full queue
    send_line(LINE_LEN - 1, 1'b0);
    send_cmd(MODE_TAKE_LINE, 4'($urandom_range(15)));
    send_line(LINE_LEN, 1'b0);
    repeat (QUEUE_DEPTH + 1) send_line($urandom_range(1, 3), 1'b0);
    repeat (QUEUE_DEPTH + 1) send_cmd(MODE_TAKE_LINE, 4'($urandom_range(15)));
    send_cmd(MODE_TAKE_ERR, 4'($urandom_range(15)));

    while (items_taken < ITEM_TARGET) random_chunk();
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("text_line_assembler_queue_core: match");
    end else begin
      $display("text_line_assembler_queue_core: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls plus one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (!rx_hold_done && items_taken >= PRESSURE_AT) begin
      rx_hold_done = 1'b1;
      rx_hold_left = STALL_HOLD;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_window() && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_result(out_data_o);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && out_stall_i === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_line_assembler_queue_core: mismatch");
        $finish;
      end
    end
  end

endmodule
